// File: rtl/mshr_pkg.sv
// ----------------------------------------------------------------------------
// mshr_pkg
// Shared constants, types and the seed mix function of the multi-source
// ranged random generator.
// ----------------------------------------------------------------------------
package mshr_pkg;

  // Field widths and seed store size
  localparam int unsigned DataW      = 32;
  localparam int unsigned SrcW       = 3;
  localparam int unsigned NumSources = 8;
  localparam int unsigned IdxW       = (NumSources > 1) ? $clog2(NumSources) : 1;
  localparam int unsigned CntW       = $clog2(DataW);
  localparam int unsigned MixSteps   = 8;
  localparam int unsigned StepW      = $clog2(MixSteps);

  localparam logic [DataW-1:0] SeedReset = 32'h1234_5678;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_DIV1,
    ST_SUM,
    ST_DIV2,
    ST_DONE
  } state_e;

  // One shift-add-xor step of the integer mix, selected by the step number
  function automatic logic [DataW-1:0] mix_step(input logic [DataW-1:0] v,
                                                input logic [StepW-1:0] step);
    logic [DataW-1:0] r;
    unique case (step)
      3'd0:    r = v + (v << 12);
      3'd1:    r = v ^ (v >> 22);
      3'd2:    r = v + (v << 4);
      3'd3:    r = v ^ (v >> 9);
      3'd4:    r = v + (v << 10);
      3'd5:    r = v ^ (v >> 2);
      3'd6:    r = v + (v << 7);
      3'd7:    r = v ^ (v >> 12);
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/mshr_req_if.sv
// ----------------------------------------------------------------------------
// mshr_req_if
// Request channel: source select and inclusive range, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mshr_req_if;
  import mshr_pkg::*;

  logic             valid;
  logic             ready;
  logic [SrcW-1:0]  source_id;
  logic [DataW-1:0] bound_lo;
  logic [DataW-1:0] bound_hi;

  modport source (output valid, source_id, bound_lo, bound_hi, input ready);
  modport sink   (input valid, source_id, bound_lo, bound_hi, output ready);
endinterface

// File: rtl/mshr_rsp_if.sv
// ----------------------------------------------------------------------------
// mshr_rsp_if
// Response channel: one reduced random value per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mshr_rsp_if;
  import mshr_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] rand_value;

  modport source (output valid, rand_value, input ready);
  modport sink   (input valid, rand_value, output ready);
endinterface

// File: rtl/multi_source_hash_rng_ranged.sv
// ----------------------------------------------------------------------------
// multi_source_hash_rng_ranged
// Per-source seed mix followed by a bit-serial double reduction into range.
// ----------------------------------------------------------------------------
// Steps: the seed mix, then two restoring divisions with the sum between them,
//   then the load of the output register; the divisions and the sum are
//   skipped when the range wraps to zero.
// Throughput: the divider yields one quotient bit per cycle; a new request is
//   accepted only in idle, once the last item has left the sequencer.
//   A finished result may wait in the output register while the next item runs.
// Reset: every seed returns to 0x12345678, sequencer idle, no result pending.
module multi_source_hash_rng_ranged (
  input  logic clk_i,
  input  logic rst_ni,
  mshr_req_if.sink   req_i,
  mshr_rsp_if.source rsp_o
);
  import mshr_pkg::*;

  state_e state_q, state_d;

  logic [DataW-1:0] seed_q [NumSources];
  logic [IdxW-1:0]  idx_q;
  logic [DataW-1:0] min_q;
  logic [DataW-1:0] range_q;
  logic [DataW-1:0] mix_q;
  logic [StepW-1:0] step_q;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] dvd_q;   // dividend, quotient bits shift in from the right
  logic [DataW-1:0] rem_q;
  logic [DataW-1:0] res_q;
  logic [DataW-1:0] out_q;
  logic             out_valid_q;

  logic             accept;
  logic             load_out;
  logic [DataW-1:0] mix_next;
  logic [DataW-1:0] seed_new;
  logic [DataW:0]   rem_sh;
  logic [DataW:0]   diff;
  logic             ge;
  logic [DataW-1:0] rem_next;
  logic [DataW-1:0] dvd_next;
  logic             mix_last;
  logic             div_last;

  // Mix step and zero fix-up
  assign mix_next = mix_step(mix_q, step_q);
  assign seed_new = (mix_next == '0) ? DataW'(1) : mix_next;
  assign mix_last = (step_q == StepW'(MixSteps - 1));
  assign div_last = (cnt_q == CntW'(DataW - 1));

  // Restoring division, one quotient bit per cycle
  assign rem_sh   = {rem_q, dvd_q[DataW-1]};
  assign diff     = rem_sh - {1'b0, range_q};
  assign ge       = ~diff[DataW];
  assign rem_next = ge ? diff[DataW-1:0] : rem_sh[DataW-1:0];
  assign dvd_next = {dvd_q[DataW-2:0], ge};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (req_i.valid) state_d = ST_MIX;
      ST_MIX: begin
        if (mix_last) state_d = (range_q == '0) ? ST_DONE : ST_DIV1;
      end
      ST_DIV1: if (div_last) state_d = ST_SUM;
      ST_SUM:  state_d = ST_DIV2;
      ST_DIV2: if (div_last) state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || rsp_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    req_i.ready = (state_q == ST_IDLE);
    load_out    = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);
  end

  assign accept           = req_i.valid && req_i.ready;
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.rand_value = out_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Seed store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSources; i++) seed_q[i] <= SeedReset;
    end else if (state_q == ST_MIX && mix_last) begin
      seed_q[idx_q] <= seed_new;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_q   <= req_i.source_id[IdxW-1:0];
          min_q   <= req_i.bound_lo;
          range_q <= req_i.bound_hi - req_i.bound_lo + DataW'(1);
          mix_q   <= seed_q[req_i.source_id[IdxW-1:0]];
          step_q  <= '0;
        end
      end
      ST_MIX: begin
        mix_q  <= mix_next;
        step_q <= step_q + StepW'(1);
        if (mix_last) begin
          dvd_q <= seed_new - DataW'(1);
          res_q <= seed_new - DataW'(1);
          rem_q <= '0;
          cnt_q <= '0;
        end
      end
      ST_DIV1, ST_DIV2: begin
        dvd_q <= dvd_next;
        rem_q <= rem_next;
        cnt_q <= cnt_q + CntW'(1);
        if (state_q == ST_DIV2 && div_last) res_q <= rem_next + min_q;
      end
      ST_SUM: begin
        // quotient plus remainder never exceeds the raw value
        dvd_q <= dvd_q + rem_q;
        rem_q <= '0;
        cnt_q <= '0;
      end
      ST_DONE: begin
        if (load_out) out_q <= res_q;
      end
      default: ;
    endcase
  end

endmodule
